// ===== sv/b57_pkg.sv =====
package b57_pkg;

    localparam int unsigned VALUE_WIDTH    = 128;
    localparam int unsigned HALF_WIDTH     = 64;
    localparam int unsigned RADIX          = 57;
    localparam int unsigned MAX_DIGITS     = 22;
    localparam int unsigned DIGIT_WIDTH    = 6;
    localparam int unsigned ACC_WIDTH      = 7;
    localparam int unsigned SYMBOL_WIDTH   = 7;
    localparam int unsigned POSITION_WIDTH = 5;
    localparam int unsigned OUT_DATA_WIDTH = 16;

    localparam logic [8*RADIX-1:0] ALPHABET_STR =
        "23456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_EMIT
    } state_t;

    // one doubling step travels from cell to cell with its carry
    typedef struct packed {
        logic step;
        logic carry;
    } cell_link_t;

    function automatic logic [SYMBOL_WIDTH-1:0] symbol_of(input logic [DIGIT_WIDTH-1:0] d);
        logic [SYMBOL_WIDTH-1:0] sym;
        sym = ALPHABET_STR[8*(RADIX-1) +: SYMBOL_WIDTH];
        if (d < DIGIT_WIDTH'(RADIX))
        begin
            sym = ALPHABET_STR[8*(int'(RADIX) - 1 - int'(d)) +: SYMBOL_WIDTH];
        end
        return sym;
    endfunction

endpackage

// ===== sv/b57_cell.sv =====
module b57_cell (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  clear,
    input  logic                                  shift,
    input  b57_pkg::cell_link_t                   link_in,
    input  logic [b57_pkg::DIGIT_WIDTH-1:0]       digit_in,
    output b57_pkg::cell_link_t                   link_out,
    output logic [b57_pkg::DIGIT_WIDTH-1:0]       digit
);

    logic [b57_pkg::DIGIT_WIDTH-1:0] digit_reg;
    logic [b57_pkg::DIGIT_WIDTH-1:0] digit_next;
    b57_pkg::cell_link_t             link_reg;
    b57_pkg::cell_link_t             link_next;
    logic [b57_pkg::ACC_WIDTH-1:0]   acc;
    logic                            wrap;

    // digit times two plus incoming carry, reduced mod 57
    assign acc  = {digit_reg, link_in.carry};
    assign wrap = (acc >= b57_pkg::ACC_WIDTH'(b57_pkg::RADIX));

    always_comb
    begin
        digit_next = digit_reg;
        link_next  = '0;
        priority if (clear)
        begin
            digit_next = '0;
        end
        else if (shift)
        begin
            digit_next = digit_in;
        end
        else if (link_in.step)
        begin
            link_next.step  = 1'b1;
            link_next.carry = wrap;
            if (wrap)
            begin
                digit_next = b57_pkg::DIGIT_WIDTH'(acc - b57_pkg::ACC_WIDTH'(b57_pkg::RADIX));
            end
            else
            begin
                digit_next = acc[b57_pkg::DIGIT_WIDTH-1:0];
            end
        end
        else
        begin
            digit_next = digit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end
        else
        begin
            link_reg <= link_next;
        end
    end

    assign link_out = link_reg;
    assign digit    = digit_reg;

endmodule

// ===== sv/base57_uuid_encoder.sv =====
// channel  | dir | handshake         | payload
// s        | in  | s_tvalid/s_tready | s_tdata: value_high[63:0], value_low[127:64]
// m        | out | m_tvalid/m_tready | m_tdata: symbol[6:0], position[11:7]; m_tlast
//
// in conversion the value enters msb first, one bit a cycle, and each doubling step ripples
// one cell per cycle; then DIGIT_COUNT output transfers follow, one a cycle while m_tready is high
// a new item is taken only when the chain is idle
// reset clears the control state; cell digits are cleared by each accepted input transfer
// m_tready low holds the output register and pauses the shift of digits out of the chain
module base57_uuid_encoder #(
    parameter int DIGIT_COUNT = 22
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [127:0] s_tdata,   // value_high[63:0], value_low[127:64]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // symbol[6:0], position[11:7], zero[15:12]
    output logic        m_tlast
);

    // digit count held to what the chain supports, 1 to 22
    localparam int NUM_DIGITS  = (DIGIT_COUNT < 1) ? 1 :
                                 (DIGIT_COUNT > int'(b57_pkg::MAX_DIGITS)) ?
                                 int'(b57_pkg::MAX_DIGITS) : DIGIT_COUNT;
    localparam int CONV_CYCLES = b57_pkg::VALUE_WIDTH + NUM_DIGITS - 1;
    localparam int CNT_W       = $clog2(CONV_CYCLES + 1);
    localparam int POS_W       = b57_pkg::POSITION_WIDTH;
    localparam int SYM_W       = b57_pkg::SYMBOL_WIDTH;
    localparam int DIG_W       = b57_pkg::DIGIT_WIDTH;

    b57_pkg::state_t                     state_reg, state_next;
    logic [b57_pkg::VALUE_WIDTH-1:0]     value_reg, value_next;
    logic [CNT_W-1:0]                    conv_cnt_reg, conv_cnt_next;
    logic [POS_W-1:0]                    emit_cnt_reg, emit_cnt_next;
    logic                                out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]                    symbol_reg, symbol_next;
    logic [POS_W-1:0]                    position_reg, position_next;
    logic                                last_reg, last_next;

    logic                                in_fire;
    logic                                out_free;
    logic                                load_out;
    logic                                cell_clear;
    logic                                cell_shift;
    logic                                emit_done;

    b57_pkg::cell_link_t                 chain_link [0:NUM_DIGITS];
    logic [DIG_W-1:0]                    cell_digit [0:NUM_DIGITS-1];

    assign s_tready   = (state_reg == b57_pkg::ST_IDLE);
    assign in_fire    = s_tvalid && s_tready;
    assign out_free   = !out_valid_reg || m_tready;
    assign cell_clear = in_fire;
    assign emit_done  = (emit_cnt_reg == POS_W'(NUM_DIGITS - 1));

    // bits feed cell 0 only until all 128 value bits have entered
    assign chain_link[0].step  = (state_reg == b57_pkg::ST_CONVERT) &&
                                 (conv_cnt_reg < CNT_W'(b57_pkg::VALUE_WIDTH));
    assign chain_link[0].carry = value_reg[b57_pkg::VALUE_WIDTH-1];

    genvar k;
    generate
        for (k = 0; k < NUM_DIGITS; k++)
        begin : g_cell
            logic [DIG_W-1:0] neighbor_digit;
            if (k == 0)
            begin : g_first
                assign neighbor_digit = '0;
            end
            else
            begin : g_rest
                assign neighbor_digit = cell_digit[k-1];
            end

            b57_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .clear    (cell_clear),
                .shift    (cell_shift),
                .link_in  (chain_link[k]),
                .digit_in (neighbor_digit),
                .link_out (chain_link[k+1]),
                .digit    (cell_digit[k])
            );
        end
    endgenerate

    always_comb
    begin
        state_next    = state_reg;
        value_next    = value_reg;
        conv_cnt_next = conv_cnt_reg;
        emit_cnt_next = emit_cnt_reg;
        load_out      = 1'b0;
        cell_shift    = 1'b0;
        unique case (state_reg)
            b57_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next    = b57_pkg::ST_CONVERT;
                    value_next    = {s_tdata[b57_pkg::HALF_WIDTH-1:0],
                                     s_tdata[b57_pkg::VALUE_WIDTH-1:b57_pkg::HALF_WIDTH]};
                    conv_cnt_next = '0;
                end
            end
            b57_pkg::ST_CONVERT:
            begin
                value_next    = {value_reg[b57_pkg::VALUE_WIDTH-2:0], 1'b0};
                conv_cnt_next = CNT_W'(conv_cnt_reg + 1'b1);
                if (conv_cnt_reg == CNT_W'(CONV_CYCLES - 1))
                begin
                    state_next    = b57_pkg::ST_EMIT;
                    emit_cnt_next = '0;
                end
            end
            b57_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    load_out      = 1'b1;
                    cell_shift    = 1'b1;
                    emit_cnt_next = POS_W'(emit_cnt_reg + 1'b1);
                    if (emit_done)
                    begin
                        state_next = b57_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = b57_pkg::ST_IDLE;
            end
        endcase
    end

    // most significant digit sits in the far end of the chain
    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        symbol_next    = symbol_reg;
        position_next  = position_reg;
        last_next      = last_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            symbol_next    = b57_pkg::symbol_of(cell_digit[NUM_DIGITS-1]);
            position_next  = emit_cnt_reg;
            last_next      = emit_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= b57_pkg::ST_IDLE;
            conv_cnt_reg  <= '0;
            emit_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            conv_cnt_reg  <= conv_cnt_next;
            emit_cnt_reg  <= emit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        symbol_reg   <= symbol_next;
        position_reg <= position_next;
        last_reg     <= last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(b57_pkg::OUT_DATA_WIDTH - SYM_W - POS_W)'(0), position_reg, symbol_reg};
    assign m_tlast  = last_reg;

    // a full 22-digit chain holds any 128-bit value, so the top cell never overflows
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (NUM_DIGITS == b57_pkg::MAX_DIGITS) |-> !chain_link[NUM_DIGITS].carry)
        else $error("carry out of the top cell");

    // every doubling step has reached the last cell before digits shift out
    a_steps_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == b57_pkg::ST_EMIT) |-> !chain_link[NUM_DIGITS-1].step)
        else $error("doubling step still in flight during output");

    // characters of one string leave with consecutive positions
    a_position_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=>
        (m_tvalid && (m_tdata[11:7] == POS_W'($past(m_tdata[11:7]) + 1'b1))))
        else $error("position does not advance by one");

endmodule

// ===== verif/base57_uuid_encoder_test.sv =====
module base57_uuid_encoder_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIGITS       = b57_pkg::MAX_DIGITS;
    localparam int RANDOM_ITEMS = 454;
    localparam int QUIET_TAIL   = 40;
    localparam int HOLD_CYCLES  = 700;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct packed {
        logic [b57_pkg::SYMBOL_WIDTH-1:0]   symbol;
        logic [b57_pkg::POSITION_WIDTH-1:0] position;
        logic                               last;
    } glyph_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [15:0]  m_tdata;
    logic         m_tlast;

    logic [b57_pkg::VALUE_WIDTH-1:0] values_to_send[$];
    glyph_t                          expected_glyphs[$];
    string                           glyphs =
        "23456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

    logic [b57_pkg::VALUE_WIDTH-1:0] next_value;
    logic                   s_took = 1'b0;
    int                     send_gap = 0;
    int                     recv_gap = 0;
    int                     hold_left = 0;
    bit                     hold_done = 1'b0;
    int                     items_sent = 0;
    int                     directed_items = 0;
    int                     total_items = 1 << 30;
    int                     glyphs_checked = 0;
    int                     errors = 0;
    int                     cycles = 0;
    bit                     quiet;

    base57_uuid_encoder #(
        .DIGIT_COUNT(DIGITS)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always #4 clk = ~clk;

    assign quiet = (items_sent >= total_items - QUIET_TAIL);

    // expected characters of one number, most significant digit first
    function automatic void encode_base57(input logic [b57_pkg::VALUE_WIDTH-1:0] value);
        logic [b57_pkg::VALUE_WIDTH-1:0] quot;
        logic [b57_pkg::DIGIT_WIDTH-1:0] digits[b57_pkg::MAX_DIGITS];
        glyph_t                          g;
        byte                             c;
        int                              n;
        n = DIGITS;
        if (n < 1)
        begin
            n = 1;
        end
        if (n > b57_pkg::MAX_DIGITS)
        begin
            n = b57_pkg::MAX_DIGITS;
        end
        quot = value;
        for (int d = 0; d < n; d++)
        begin
            digits[d] = b57_pkg::DIGIT_WIDTH'(quot % b57_pkg::RADIX);
            quot      = quot / b57_pkg::RADIX;
        end
        for (int d = 0; d < n; d++)
        begin
            c          = glyphs[digits[n - 1 - d]];
            g.symbol   = c[b57_pkg::SYMBOL_WIDTH-1:0];
            g.position = b57_pkg::POSITION_WIDTH'(d);
            g.last     = (d == n - 1);
            expected_glyphs.push_back(g);
        end
    endfunction

    function automatic logic [b57_pkg::VALUE_WIDTH-1:0] pow57(input int k);
        logic [b57_pkg::VALUE_WIDTH-1:0] p;
        p = 1;
        for (int i = 0; i < k; i++)
        begin
            p = p * b57_pkg::RADIX;
        end
        return p;
    endfunction

    function automatic logic [b57_pkg::VALUE_WIDTH-1:0] random_value();
        logic [b57_pkg::VALUE_WIDTH-1:0] v;
        int                              k;
        v = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v = v;
            1: v = b57_pkg::VALUE_WIDTH'($urandom_range(0, 57 * 57 * 57));
            2:
            begin
                k = $urandom_range(0, b57_pkg::MAX_DIGITS - 1);
                v = pow57(k) + b57_pkg::VALUE_WIDTH'($urandom_range(0, 2)) - 1;
            end
            3:
            begin
                k = $urandom_range(0, b57_pkg::VALUE_WIDTH - 1);
                v = b57_pkg::VALUE_WIDTH'(1) << k;
                if ($urandom_range(0, 1))
                begin
                    v = ~v;
                end
            end
            4: v[127:64] = '0;
            default: v[63:0] = '0;
        endcase
        return v;
    endfunction

    // sender: offers queued numbers, with random gaps between transfers
    always @(negedge clk)
    begin
        if (s_tvalid && !s_took)
        begin
        end
        else if (send_gap > 0)
        begin
            s_tvalid <= 1'b0;
            send_gap = send_gap - 1;
        end
        else if (rst_n && values_to_send.size() != 0)
        begin
            next_value = values_to_send.pop_front();
            s_tdata  <= {next_value[63:0], next_value[127:64]};
            s_tvalid <= 1'b1;
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                send_gap = $urandom_range(1, 6);
            end
        end
        else
        begin
            s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        s_took <= s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            encode_base57({s_tdata[63:0], s_tdata[127:64]});
            items_sent <= items_sent + 1;
        end
    end

    // long output hold-off once traffic is flowing, so the input backs up
    always @(negedge clk)
    begin
        if (!hold_done && glyphs_checked >= 60)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            m_tready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            m_tready <= 1'b0;
            recv_gap = recv_gap - 1;
        end
        else if (!quiet && $urandom_range(0, 4) == 0)
        begin
            m_tready <= 1'b0;
            recv_gap = $urandom_range(0, 5);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        glyph_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_glyphs.size() == 0)
            begin
                $display("%0t: unexpected transfer, got symbol %0d position %0d last %0d",
                         $time, m_tdata[6:0], m_tdata[11:7], m_tlast);
                errors++;
            end
            else
            begin
                want = expected_glyphs.pop_front();
                if (m_tdata[6:0] !== want.symbol || m_tdata[11:7] !== want.position
                    || m_tlast !== want.last)
                begin
                    $display("%0t: expected symbol %0d position %0d last %0d, got %0d %0d %0d",
                             $time, want.symbol, want.position, want.last,
                             m_tdata[6:0], m_tdata[11:7], m_tlast);
                    errors++;
                end
            end
            glyphs_checked <= glyphs_checked + 1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        // directed: extremes, digit boundaries, single halves
        values_to_send.push_back('0);
        values_to_send.push_back(b57_pkg::VALUE_WIDTH'(1));
        values_to_send.push_back(b57_pkg::VALUE_WIDTH'(56));
        values_to_send.push_back(b57_pkg::VALUE_WIDTH'(57));
        values_to_send.push_back({b57_pkg::VALUE_WIDTH{1'b1}});
        values_to_send.push_back({1'b1, 127'b0});
        values_to_send.push_back({64'b0, {64{1'b1}}});
        values_to_send.push_back({{63{1'b0}}, 1'b1, 64'b0});
        values_to_send.push_back({{64{1'b1}}, 64'b0});
        values_to_send.push_back({64{2'b10}});
        values_to_send.push_back({64{2'b01}});
        values_to_send.push_back(pow57(21));
        values_to_send.push_back(pow57(21) - 1);
        values_to_send.push_back(pow57(11) - 1);
        values_to_send.push_back(pow57(11));
        values_to_send.push_back(pow57(21) * 56);
        directed_items = values_to_send.size();
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            values_to_send.push_back(random_value());
        end
        total_items = values_to_send.size();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (values_to_send.size() != 0 || s_tvalid)
        begin
            @(posedge clk);
        end
        while (expected_glyphs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (200) @(posedge clk);

        $display("encoded %0d numbers (%0d directed, rest random), %0d characters checked",
                 items_sent, directed_items, glyphs_checked);
        $display("random gaps on both sides and one %0d-cycle output hold-off", HOLD_CYCLES);
        if (errors == 0 && expected_glyphs.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== base57_uuid_encoder.f =====
sv/b57_pkg.sv
sv/b57_cell.sv
sv/base57_uuid_encoder.sv
verif/base57_uuid_encoder_test.sv
